// ----- hdl/led_ring_clock_pixel_color_defines.svh -----
// Assertion macros for the LED ring clock pixel color block.
// Used by led_ring_clock_pixel_color.sv; needs clk and arst_n in scope.
`ifndef LED_RING_CLOCK_PIXEL_COLOR_DEFINES_SVH
`define LED_RING_CLOCK_PIXEL_COLOR_DEFINES_SVH

// antecedent in one cycle, consequent in the next
`define LRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("led ring clock: next-cycle check failed");

// antecedent and consequent in the same cycle
`define LRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("led ring clock: same-cycle check failed");

`endif

// ----- hdl/lrc_pkg.sv -----
// Package for the LED ring clock pixel color block: beat types, ring sizes,
// register indexes and constant-divide helpers. No dependencies.
`default_nettype none

package lrc_pkg;

	localparam int OUTER_RING_PIXELS  = 60;
	localparam int MIDDLE_RING_PIXELS = 24;
	localparam int INNER_RING_PIXELS  = 12;
	localparam int CHAIN_PIXELS = OUTER_RING_PIXELS + MIDDLE_RING_PIXELS + INNER_RING_PIXELS;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int HOURS_ON_DIAL    = 12;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MARK_LEVEL     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HAND_LEVEL     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_LEVEL = 2'd2;

	localparam logic [7:0] MARK_LEVEL_RST     = 8'd15;
	localparam logic [7:0] HAND_LEVEL_RST     = 8'd255;
	localparam logic [7:0] NEIGHBOR_LEVEL_RST = 8'd31;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] pixel_index;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_rgb_t;

	// v / 5 for v < 128, by reciprocal 205/1024
	function automatic logic [4:0] div5(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return 5'(p >> 10);
	endfunction

	// v / 12 for v < 64, by reciprocal 43/512
	function automatic logic [2:0] div12(input logic [5:0] v);
		logic [11:0] p;
		p = 12'(v) * 12'd43;
		return 3'(p >> 9);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/led_ring_clock_pixel_color.sv -----
// LED ring clock pixel color: top level and the whole datapath.
// Depends on lrc_pkg and led_ring_clock_pixel_color_defines.svh.
//
// One pixel query is taken on every cycle (busy stays low). Its color passes the
// query register and then the result register, and is shown for one cycle on
// result with result_valid high. The layer logic between the two registers is a
// single pass. There is no back-pressure: the receiver must take each result in
// the cycle it is shown. Register writes are always ready and take effect on the
// next query in the logic.
`default_nettype none

`include "led_ring_clock_pixel_color_defines.svh"

module led_ring_clock_pixel_color (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire lrc_pkg::pix_req_t               req,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data,
	output logic                                 result_valid,
	output lrc_pkg::pix_rgb_t                    result
);

	typedef enum logic [1:0] {
		RING_OUTER,
		RING_MIDDLE,
		RING_INNER,
		RING_NONE
	} ring_t;

	logic              valid_s1;
	lrc_pkg::pix_req_t req_s1;
	logic              valid_s2;
	lrc_pkg::pix_rgb_t rgb_s2;

	logic [7:0] mark_level_q;
	logic [7:0] hand_level_q;
	logic [7:0] neighbor_level_q;

	ring_t             ring;
	logic [5:0]        pos;
	logic              hour_ok, min_ok, sec_ok;
	logic [3:0]        h12;
	logic [5:0]        hdot, hlast, hnext, hprev;
	logic [5:0]        mdot;
	logic [4:0]        mark_q5;
	lrc_pkg::pix_rgb_t rgb;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_level_q     <= lrc_pkg::MARK_LEVEL_RST;
			hand_level_q     <= lrc_pkg::HAND_LEVEL_RST;
			neighbor_level_q <= lrc_pkg::NEIGHBOR_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lrc_pkg::CFG_MARK_LEVEL:     mark_level_q     <= cfg_data;
				lrc_pkg::CFG_HAND_LEVEL:     hand_level_q     <= cfg_data;
				lrc_pkg::CFG_NEIGHBOR_LEVEL: neighbor_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rgb_s2 <= rgb;
		end
	end

	always_comb begin
		ring = RING_NONE;
		pos  = '0;
		if (req_s1.pixel_index < 7'(lrc_pkg::OUTER_RING_PIXELS)) begin
			ring = RING_OUTER;
			pos  = req_s1.pixel_index[5:0];
		end else if (req_s1.pixel_index <
				7'(lrc_pkg::OUTER_RING_PIXELS + lrc_pkg::MIDDLE_RING_PIXELS)) begin
			ring = RING_MIDDLE;
			pos  = 6'(req_s1.pixel_index - 7'(lrc_pkg::OUTER_RING_PIXELS));
		end else if (req_s1.pixel_index < 7'(lrc_pkg::CHAIN_PIXELS)) begin
			ring = RING_INNER;
			pos  = 6'(req_s1.pixel_index -
				7'(lrc_pkg::OUTER_RING_PIXELS + lrc_pkg::MIDDLE_RING_PIXELS));
		end
	end

	always_comb begin
		hour_ok = req_s1.hour < 5'(2 * lrc_pkg::HOURS_ON_DIAL);
		min_ok  = req_s1.minute < 6'(lrc_pkg::MINUTES_PER_HOUR);
		sec_ok  = req_s1.second < 6'(lrc_pkg::MINUTES_PER_HOUR);
		h12 = (req_s1.hour >= 5'(lrc_pkg::HOURS_ON_DIAL)) ?
			4'(req_s1.hour - 5'(lrc_pkg::HOURS_ON_DIAL)) : req_s1.hour[3:0];
		mark_q5 = lrc_pkg::div5({1'b0, pos});

		case (ring)
			RING_OUTER: begin
				hdot  = 6'(6'(h12) * 6'd5) + 6'(lrc_pkg::div12(req_s1.minute));
				hlast = 6'(lrc_pkg::OUTER_RING_PIXELS - 1);
				mdot  = req_s1.minute;
			end
			RING_MIDDLE: begin
				hdot  = 6'({h12, 1'b0}) + 6'(req_s1.minute >= 6'd30);
				hlast = 6'(lrc_pkg::MIDDLE_RING_PIXELS - 1);
				mdot  = 6'(lrc_pkg::div5({req_s1.minute, 1'b0}));
			end
			RING_INNER: begin
				hdot  = '0;
				hlast = 6'(lrc_pkg::INNER_RING_PIXELS - 1);
				mdot  = 6'(lrc_pkg::div5({1'b0, req_s1.minute}));
			end
			default: begin
				hdot  = '0;
				hlast = '0;
				mdot  = '0;
			end
		endcase
		hnext = (hdot == hlast) ? 6'd0 : 6'(hdot + 6'd1);
		hprev = (hdot == 6'd0) ? hlast : 6'(hdot - 6'd1);

		rgb = '0;
		if (ring == RING_OUTER && 7'(7'(mark_q5) * 7'd5) == {1'b0, pos}) begin
			rgb = '{mark_level_q, mark_level_q, mark_level_q};
		end
		if ((ring == RING_OUTER || ring == RING_MIDDLE) && hour_ok && min_ok) begin
			if (pos == hdot) begin
				rgb = '{8'd0, hand_level_q, 8'd0};
			end
			if (pos == hnext || pos == hprev) begin
				rgb = '{8'd0, neighbor_level_q, 8'd0};
			end
		end
		if (ring != RING_NONE && min_ok && pos == mdot) begin
			rgb = '{8'd0, 8'd0, hand_level_q};
		end
		if (ring == RING_OUTER && sec_ok && pos == req_s1.second) begin
			rgb = '{hand_level_q, 8'd0, hand_level_q};
		end
	end

	assign result_valid = valid_s2;
	assign result       = rgb_s2;

	`LRC_ASSERT_NEXT(a_strobe_follows_query, valid_s1, result_valid)
	`LRC_ASSERT_NEXT(a_no_strobe_without_query, !valid_s1, !result_valid)
	`LRC_ASSERT_NEXT(a_off_chain_dark,
		valid_s1 && req_s1.pixel_index >= 7'(lrc_pkg::CHAIN_PIXELS), result == '0)
	`LRC_ASSERT_NOW(a_second_dot_magenta,
		valid_s2 && $past(valid_s1 && ring == RING_OUTER && sec_ok && pos == req_s1.second),
		result.green == 8'd0 && result.red == result.blue)

endmodule

`default_nettype wire

// ----- verif/led_ring_clock_pixel_color_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for led_ring_clock_pixel_color: drives pixel queries and
// level register writes, predicts each pixel's color and checks every result beat.
// Depends on lrc_pkg and the led_ring_clock_pixel_color RTL.
module led_ring_clock_pixel_color_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int BLOCK_QUERIES = 125;

	class color_checker;
		logic [7:0]        mark_lvl;
		logic [7:0]        hand_lvl;
		logic [7:0]        nbr_lvl;
		lrc_pkg::pix_rgb_t colors_due[$];
		int                errors;

		function new();
			mark_lvl = lrc_pkg::MARK_LEVEL_RST;
			hand_lvl = lrc_pkg::HAND_LEVEL_RST;
			nbr_lvl  = lrc_pkg::NEIGHBOR_LEVEL_RST;
			errors   = 0;
		endfunction

		static function int hour_dot(int n, int h12, int minute);
			return ((n * h12) / lrc_pkg::HOURS_ON_DIAL +
				(n * minute) / (lrc_pkg::MINUTES_PER_HOUR * lrc_pkg::HOURS_ON_DIAL)) % n;
		endfunction

		function void set_level(logic [lrc_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] v);
			case (idx)
				lrc_pkg::CFG_MARK_LEVEL:     mark_lvl = v;
				lrc_pkg::CFG_HAND_LEVEL:     hand_lvl = v;
				lrc_pkg::CFG_NEIGHBOR_LEVEL: nbr_lvl  = v;
				default: ;
			endcase
		endfunction

		function lrc_pkg::pix_rgb_t pixel_color(lrc_pkg::pix_req_t q);
			lrc_pkg::pix_rgb_t c;
			int idx, hr, mn, sc, n, pos, dot;
			c   = '0;
			idx = int'(q.pixel_index);
			hr  = int'(q.hour);
			mn  = int'(q.minute);
			sc  = int'(q.second);
			if (idx >= lrc_pkg::CHAIN_PIXELS)
				return c;
			if (idx < lrc_pkg::OUTER_RING_PIXELS) begin
				n   = lrc_pkg::OUTER_RING_PIXELS;
				pos = idx;
			end else if (idx < lrc_pkg::OUTER_RING_PIXELS + lrc_pkg::MIDDLE_RING_PIXELS) begin
				n   = lrc_pkg::MIDDLE_RING_PIXELS;
				pos = idx - lrc_pkg::OUTER_RING_PIXELS;
			end else begin
				n   = lrc_pkg::INNER_RING_PIXELS;
				pos = idx - lrc_pkg::OUTER_RING_PIXELS - lrc_pkg::MIDDLE_RING_PIXELS;
			end
			if (n == lrc_pkg::OUTER_RING_PIXELS &&
				pos % (lrc_pkg::OUTER_RING_PIXELS / lrc_pkg::HOURS_ON_DIAL) == 0)
				c = '{mark_lvl, mark_lvl, mark_lvl};
			if (n != lrc_pkg::INNER_RING_PIXELS && hr < 2 * lrc_pkg::HOURS_ON_DIAL &&
				mn < lrc_pkg::MINUTES_PER_HOUR) begin
				dot = hour_dot(n, hr % lrc_pkg::HOURS_ON_DIAL, mn);
				if (pos == dot)
					c = '{8'd0, hand_lvl, 8'd0};
				if (pos == (dot + 1) % n || pos == (dot + n - 1) % n)
					c = '{8'd0, nbr_lvl, 8'd0};
			end
			if (mn < lrc_pkg::MINUTES_PER_HOUR && pos == n * mn / lrc_pkg::MINUTES_PER_HOUR)
				c = '{8'd0, 8'd0, hand_lvl};
			if (n == lrc_pkg::OUTER_RING_PIXELS && sc < lrc_pkg::MINUTES_PER_HOUR &&
				pos == lrc_pkg::OUTER_RING_PIXELS * sc / lrc_pkg::MINUTES_PER_HOUR)
				c = '{hand_lvl, 8'd0, hand_lvl};
			return c;
		endfunction

		function void note_query(lrc_pkg::pix_req_t q);
			colors_due.push_back(pixel_color(q));
		endfunction

		function int pending();
			return colors_due.size();
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_color(lrc_pkg::pix_rgb_t got);
			lrc_pkg::pix_rgb_t want;
			if (colors_due.size() == 0) begin
				report("result beat with no query outstanding");
				return;
			end
			want = colors_due.pop_front();
			if (got.red !== want.red)
				report($sformatf("red got %0d want %0d", got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("green got %0d want %0d", got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("blue got %0d want %0d", got.blue, want.blue));
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	lrc_pkg::pix_req_t               req;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lrc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]                      cfg_data;
	logic                            result_valid;
	lrc_pkg::pix_rgb_t               result;

	color_checker board;
	int           cycle_count = 0;

	always #1 clk = ~clk;

	led_ring_clock_pixel_color u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_level(cfg_index, cfg_data);
			if (start && !busy)
				board.note_query(req);
			if (result_valid)
				board.check_color(result);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic lrc_pkg::pix_req_t make_query(int h, int m, int s, int p);
		lrc_pkg::pix_req_t q;
		q.hour        = 5'(h);
		q.minute      = 6'(m);
		q.second      = 6'(s);
		q.pixel_index = 7'(p);
		return q;
	endfunction

	// mostly valid times aimed at dots, neighbors and marks; some full-range noise
	function automatic lrc_pkg::pix_req_t random_query();
		lrc_pkg::pix_req_t q;
		int n, base, pos, pick;
		q.hour   = 5'($urandom_range(2 * lrc_pkg::HOURS_ON_DIAL - 1));
		q.minute = 6'($urandom_range(lrc_pkg::MINUTES_PER_HOUR - 1));
		q.second = 6'($urandom_range(lrc_pkg::MINUTES_PER_HOUR - 1));
		pick = $urandom_range(99);
		if (pick < 10) begin
			q.hour        = 5'($urandom_range(31));
			q.minute      = 6'($urandom_range(63));
			q.second      = 6'($urandom_range(63));
			q.pixel_index = 7'($urandom_range(127));
			return q;
		end
		q.pixel_index = 7'($urandom_range(lrc_pkg::CHAIN_PIXELS - 1));
		if (pick < 50)
			return q;
		case ($urandom_range(2))
			0: begin
				n    = lrc_pkg::OUTER_RING_PIXELS;
				base = 0;
			end
			1: begin
				n    = lrc_pkg::MIDDLE_RING_PIXELS;
				base = lrc_pkg::OUTER_RING_PIXELS;
			end
			default: begin
				n    = lrc_pkg::INNER_RING_PIXELS;
				base = lrc_pkg::OUTER_RING_PIXELS + lrc_pkg::MIDDLE_RING_PIXELS;
			end
		endcase
		case ($urandom_range(3))
			0: pos = (color_checker::hour_dot(n, int'(q.hour) % lrc_pkg::HOURS_ON_DIAL,
				int'(q.minute)) + n - 1 + int'($urandom_range(2))) % n;
			1: pos = n * int'(q.minute) / lrc_pkg::MINUTES_PER_HOUR;
			2: pos = int'(q.second) % n;
			default: pos = (lrc_pkg::OUTER_RING_PIXELS / lrc_pkg::HOURS_ON_DIAL) *
				int'($urandom_range(lrc_pkg::HOURS_ON_DIAL - 1)) % n;
		endcase
		q.pixel_index = 7'(base + pos);
		return q;
	endfunction

	task automatic send_query(input lrc_pkg::pix_req_t q, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= q;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic cfg_beat(input logic [lrc_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_levels(input logic [7:0] mark, input logic [7:0] hand,
		input logic [7:0] nbr);
		cfg_beat(lrc_pkg::CFG_MARK_LEVEL, mark);
		cfg_beat(lrc_pkg::CFG_HAND_LEVEL, hand);
		cfg_beat(lrc_pkg::CFG_NEIGHBOR_LEVEL, nbr);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int blk, k, idle;
		board     = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = lrc_pkg::CFG_MARK_LEVEL;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at reset levels
		send_query(make_query(0, 0, 0, 0), 0);
		send_query(make_query(23, 59, 59, 59), 0);
		send_query(make_query(11, 59, 30, 0), 0);
		send_query(make_query(11, 59, 30, 58), 0);
		send_query(make_query(11, 59, 30, 57), 0);
		send_query(make_query(11, 59, 30, 60), 0);
		send_query(make_query(11, 59, 30, 82), 0);
		send_query(make_query(12, 30, 1, 60), 0);
		send_query(make_query(12, 30, 1, 61), 0);
		send_query(make_query(12, 30, 1, 62), 0);
		send_query(make_query(5, 30, 10, 90), 0);
		send_query(make_query(5, 30, 10, 95), 0);
		send_query(make_query(5, 30, 10, 84), 0);
		send_query(make_query(3, 20, 45, 5), 0);
		send_query(make_query(3, 20, 45, 16), 0);
		send_query(make_query(3, 20, 45, 45), 0);
		send_query(make_query(24, 10, 10, 10), 0);
		send_query(make_query(31, 10, 63, 10), 0);
		send_query(make_query(6, 63, 20, 30), 0);
		send_query(make_query(6, 60, 20, 80), 0);
		send_query(make_query(6, 10, 63, 0), 0);
		send_query(make_query(6, 10, 20, 96), 0);
		send_query(make_query(31, 63, 63, 127), 0);
		drain_results();

		for (blk = 0; blk < 6; blk++) begin
			case (blk)
				0: program_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				1: program_levels(8'd0, 8'd0, 8'd0);
				2: program_levels(8'd255, 8'd255, 8'd255);
				3: program_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
				4: program_levels(8'd0, 8'd255, 8'd0);
				default: program_levels(8'd255, 8'd0, 8'd255);
			endcase
			idle = (blk < 2) ? 31 : (blk < 4) ? 75 : 0;
			for (k = 0; k < BLOCK_QUERIES; k++) begin
				send_query(random_query(), idle);
				if ($urandom_range(99) == 0)
					drain_results();
			end
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (board.pending() != 0)
			board.report("results still outstanding at end of run");
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- led_ring_clock_pixel_color.f -----
+incdir+hdl
hdl/lrc_pkg.sv
hdl/led_ring_clock_pixel_color.sv
verif/led_ring_clock_pixel_color_tb.sv
